// ===== src/lws_pkg.sv =====
// package of the led line write sequencer: control word, microcode rom and byte tables
`timescale 1ns / 1ps

package lws_pkg;

  localparam int STEP_W    = 4;
  localparam int NUM_STEPS = 13;

  localparam logic [7:0] OFF_CTRL = 8'ha8;
  localparam logic [7:0] OFF_DATA = 8'hac;

  // where the write data byte comes from
  typedef enum logic [1:0] {
    SRC_CONST = 2'd0,  // literal byte in the control word
    SRC_VAR   = 2'd1,  // init bytes or state bytes, indexed by step low bits
    SRC_FINAL = 2'd2   // final byte of the target state
  } data_src_t;

  // what happens after the step
  typedef enum logic [1:0] {
    JMP_NEXT        = 2'd0,
    JMP_END_IF_INIT = 2'd1,
    JMP_END         = 2'd2
  } jump_t;

  typedef struct packed {
    logic [7:0] offset;
    data_src_t  src;
    logic [7:0] data;
    jump_t      jump;
  } ctrl_word_t;

  function automatic ctrl_word_t ucode_rom(input logic [STEP_W-1:0] step);
    ctrl_word_t w;
    w = '{offset: OFF_CTRL, src: SRC_CONST, data: 8'h00, jump: JMP_END};
    case (step)
      4'd0:  w = '{offset: OFF_CTRL,        src: SRC_CONST, data: 8'h58, jump: JMP_NEXT};
      4'd1:  w = '{offset: OFF_CTRL + 8'd1, src: SRC_CONST, data: 8'h02, jump: JMP_NEXT};
      4'd2:  w = '{offset: OFF_CTRL + 8'd2, src: SRC_CONST, data: 8'h00, jump: JMP_NEXT};
      4'd3:  w = '{offset: OFF_CTRL + 8'd3, src: SRC_CONST, data: 8'h00, jump: JMP_NEXT};
      4'd4:  w = '{offset: OFF_DATA,        src: SRC_VAR,   data: 8'h00, jump: JMP_NEXT};
      4'd5:  w = '{offset: OFF_DATA + 8'd1, src: SRC_VAR,   data: 8'h00, jump: JMP_NEXT};
      4'd6:  w = '{offset: OFF_DATA + 8'd2, src: SRC_VAR,   data: 8'h00, jump: JMP_NEXT};
      4'd7:  w = '{offset: OFF_DATA + 8'd3, src: SRC_VAR,   data: 8'h00,
                   jump: JMP_END_IF_INIT};
      4'd8:  w = '{offset: OFF_CTRL,        src: SRC_CONST, data: 8'h24, jump: JMP_NEXT};
      4'd9:  w = '{offset: OFF_CTRL + 8'd1, src: SRC_CONST, data: 8'h02, jump: JMP_NEXT};
      4'd10: w = '{offset: OFF_CTRL + 8'd2, src: SRC_CONST, data: 8'h00, jump: JMP_NEXT};
      4'd11: w = '{offset: OFF_CTRL + 8'd3, src: SRC_CONST, data: 8'h00, jump: JMP_NEXT};
      4'd12: w = '{offset: OFF_DATA,        src: SRC_FINAL, data: 8'h00, jump: JMP_END};
      default: w = '{offset: OFF_CTRL, src: SRC_CONST, data: 8'h00, jump: JMP_END};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] init_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h10;
      2'd1:    b = 8'h32;
      2'd2:    b = 8'h54;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] state_byte(input logic [1:0] state, input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h10;
      2'd1:    b = (state == 2'd2) ? 8'h32 : 8'h37;
      2'd2:    b = (state == 2'd1) ? 8'h54 : 8'h57;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] final_byte(input logic [1:0] state);
    logic [7:0] b;
    case (state)
      2'd0:    b = 8'hff;
      2'd1:    b = 8'hfb;
      2'd2:    b = 8'hef;
      default: b = 8'heb;
    endcase
    return b;
  endfunction

endpackage

// ===== src/lws_if.sv =====
// valid/ready channel interfaces for the led line write sequencer
`timescale 1ns / 1ps

interface lws_in_if;
  logic valid;
  logic ready;
  logic opcode;
  logic line_select;
  logic line_value;

  modport source (output valid, opcode, line_select, line_value, input ready);
  modport sink   (input valid, opcode, line_select, line_value, output ready);
endinterface

interface lws_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [7:0]  write_data;
  logic        last_write;

  modport source (output valid, write_address, write_data, last_write, input ready);
  modport sink   (input valid, write_address, write_data, last_write, output ready);
endinterface

// ===== src/led_line_write_sequencer.sv =====
// top level of the led line write sequencer
`timescale 1ns / 1ps

// Holds two led line bits and turns every change of them into a fixed program
// of byte writes (window base plus offset, data, last mark). A set item that
// changes the state runs 13 writes, an init item runs 8, a set item that leaves
// the state alone produces nothing. Control comes from a 13-step microcode
// rom walked by a step counter: one write leaves per cycle into the output
// register, but not while a write sits there and the sink holds ready low.
// A new item is taken only between programs; the last write of a program may
// still sit in the output register while it is taken.
// window_base is sampled at each write, so only change it while idle.
module led_line_write_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  lws_in_if.sink      in_item,
  lws_out_if.source   out_item,
  input  logic        cfg_wr_en,
  input  logic [31:0] cfg_wr_data
);

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_t;

  state_t                       state_r;
  logic [lws_pkg::STEP_W-1:0]   step_r;
  logic                         init_r;      // program in flight is the init program
  logic [1:0]                   target_r;    // state whose program is in flight
  logic [1:0]                   led_lines_r;
  logic [31:0]                  window_base_r;

  logic                         out_valid_r;
  logic [31:0]                  out_addr_r;
  logic [7:0]                   out_data_r;
  logic                         out_last_r;

  logic                         in_xfer;
  logic [1:0]                   lines_nxt;
  logic                         start;
  logic                         emit;
  logic                         done;
  lws_pkg::ctrl_word_t          cw;
  logic [7:0]                   data_nxt;

  assign in_item.ready = (state_r == ST_IDLE);
  assign in_xfer       = in_item.valid && in_item.ready;

  // new line state from a set item
  always_comb begin
    lines_nxt = led_lines_r;
    lines_nxt[in_item.line_select] = in_item.line_value;
  end

  assign start = in_xfer && (in_item.opcode || (lines_nxt != led_lines_r));

  // one microcode step per cycle whenever the output register is free
  assign cw   = lws_pkg::ucode_rom(step_r);
  assign emit = (state_r == ST_RUN) && (!out_valid_r || out_item.ready);
  assign done = (cw.jump == lws_pkg::JMP_END) ||
                ((cw.jump == lws_pkg::JMP_END_IF_INIT) && init_r);

  always_comb begin
    case (cw.src)
      lws_pkg::SRC_CONST: data_nxt = cw.data;
      lws_pkg::SRC_VAR:   data_nxt = init_r ? lws_pkg::init_byte(step_r[1:0])
                                            : lws_pkg::state_byte(target_r, step_r[1:0]);
      lws_pkg::SRC_FINAL: data_nxt = lws_pkg::final_byte(target_r);
      default:            data_nxt = cw.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      init_r        <= 1'b0;
      target_r      <= '0;
      led_lines_r   <= '0;
      window_base_r <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        window_base_r <= cfg_wr_data;
      end

      // item intake: latch the program choice, commit the new state now
      if (start) begin
        state_r  <= ST_RUN;
        step_r   <= '0;
        init_r   <= in_item.opcode;
        target_r <= lines_nxt;
        if (!in_item.opcode) begin
          led_lines_r <= lines_nxt;
        end
      end

      if (emit) begin
        out_valid_r <= 1'b1;
        if (done) begin
          state_r <= ST_IDLE;
        end else begin
          step_r <= step_r + 1'b1;
        end
      end else if (out_item.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload of the output register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_addr_r <= window_base_r + {24'd0, cw.offset};
      out_data_r <= data_nxt;
      out_last_r <= done;
    end
  end

  assign out_item.valid         = out_valid_r;
  assign out_item.write_address = out_addr_r;
  assign out_item.write_data    = out_data_r;
  assign out_item.last_write    = out_last_r;

  // step counter never runs past the program
  a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN) |-> (step_r < lws_pkg::STEP_W'(lws_pkg::NUM_STEPS)))
    else $error("step counter beyond program");

  // init program ends at the eighth write
  a_init_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RUN && init_r) |-> (step_r <= lws_pkg::STEP_W'(7)))
    else $error("init program overran");

  // a set item that leaves the lines alone starts nothing
  a_no_change: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && !in_item.opcode && lines_nxt == led_lines_r) |=> (state_r == ST_IDLE))
    else $error("program started without a state change");

  // line state moves only on an accepted transfer
  a_lines_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_xfer |=> $stable(led_lines_r))
    else $error("led lines changed without a transfer");

endmodule

// ===== tb/led_line_write_sequencer_tb.sv =====
// testbench of the led line write sequencer: random and directed items against a predictor
`timescale 1ns / 1ps

module led_line_write_sequencer_tb;

  // item codes
  localparam logic OP_SET     = 1'b0;
  localparam logic OP_INIT    = 1'b1;
  localparam logic LINE_DISK3 = 1'b0;
  localparam logic LINE_DISK4 = 1'b1;

  // byte programs, first byte in the top byte lane
  localparam logic [31:0] PREAMBLE_BYTES = 32'h58_02_00_00;
  localparam logic [31:0] INIT_BYTES     = 32'h10_32_54_00;
  localparam logic [31:0] SELECT_BYTES   = 32'h24_02_00_00;
  localparam logic [31:0] FINAL_BYTES    = 32'hff_fb_ef_eb;  // one byte per state 0..3

  localparam int LIMIT_CYCLES = 200000;
  localparam int SETTLE_CYCLES = 16;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic opcode;
    logic line_select;
    logic line_value;
  } led_cmd_t;

  typedef struct packed {
    logic [31:0] address;
    logic [7:0]  data;
    logic        last;
  } byte_write_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [31:0] cfg_wr_data;

  lws_in_if  in_ch ();
  lws_out_if out_ch ();

  led_line_write_sequencer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_item     (in_ch),
    .out_item    (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  led_cmd_t    pending_cmds[$];
  byte_write_t expected_writes[$];

  // predictor state: its own copy of the line bits and of the window base
  logic [1:0]  held_lines = 2'd0;
  logic [31:0] base_copy = 32'd0;

  int send_idle_pct = 36;
  int recv_idle_pct = 83;
  int mismatch_count = 0;
  int cycle_count = 0;

  // toggled to ask the receiver for one long hold-off
  logic hold_req = 1'b0;
  logic hold_ack = 1'b0;
  int   hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // queue a segment of byte writes at auto-incrementing offsets
  task automatic push_segment(input logic [7:0] offset, input logic [31:0] bytes,
                              input int count, input logic ends_program);
    byte_write_t w;
    for (int i = 0; i < count; i++) begin
      w.address = base_copy + {24'd0, offset} + 32'(i);
      w.data    = bytes[31 - 8*i -: 8];
      w.last    = ends_program && (i == count - 1);
      expected_writes.push_back(w);
    end
  endtask

  // expected writes of one accepted command
  task automatic predict_writes(input led_cmd_t cmd);
    logic [1:0]  next_lines;
    logic [31:0] state_bytes;
    if (cmd.opcode == OP_INIT) begin
      // select and value are ignored, lines are kept
      push_segment(lws_pkg::OFF_CTRL, PREAMBLE_BYTES, 4, 1'b0);
      push_segment(lws_pkg::OFF_DATA, INIT_BYTES, 4, 1'b1);
    end else begin
      next_lines = held_lines;
      next_lines[cmd.line_select] = cmd.line_value;
      // unchanged lines: nothing is written
      if (next_lines != held_lines) begin
        case (next_lines)
          2'd1:    state_bytes = 32'h10_37_54_00;
          2'd2:    state_bytes = 32'h10_32_57_00;
          default: state_bytes = 32'h10_37_57_00;  // both and disk34 share it
        endcase
        push_segment(lws_pkg::OFF_CTRL, PREAMBLE_BYTES, 4, 1'b0);
        push_segment(lws_pkg::OFF_DATA, state_bytes, 4, 1'b0);
        push_segment(lws_pkg::OFF_CTRL, SELECT_BYTES, 4, 1'b0);
        push_segment(lws_pkg::OFF_DATA, {FINAL_BYTES[31 - 8*next_lines -: 8], 24'd0}, 1,
                     1'b1);
        held_lines = next_lines;
      end
    end
  endtask

  // driver: offers queued commands, predicts on each transfer
  always @(posedge clk) begin : cmd_driver
    led_cmd_t cmd;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cmd = '{opcode: in_ch.opcode, line_select: in_ch.line_select,
                line_value: in_ch.line_value};
        predict_writes(cmd);
      end
      // hold the item until it is taken
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          cmd = pending_cmds.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.opcode      <= cmd.opcode;
          in_ch.line_select <= cmd.line_select;
          in_ch.line_value  <= cmd.line_value;
        end else begin
          // idle cycle with junk on the payload
          in_ch.valid       <= 1'b0;
          in_ch.opcode      <= 1'($urandom_range(0, 1));
          in_ch.line_select <= 1'($urandom_range(0, 1));
          in_ch.line_value  <= 1'($urandom_range(0, 1));
        end
      end
    end
  end

  // receiver: random ready, plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack     <= hold_req;
      hold_left    <= HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left    <= hold_left - 1;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // monitor: every write transfer against the oldest expectation
  always @(posedge clk) begin : write_monitor
    byte_write_t exp_w;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_writes.size() == 0) begin
        mismatch_count++;
        $display("%0t unexpected write: addr %h data %h last %b", $time,
                 out_ch.write_address, out_ch.write_data, out_ch.last_write);
      end else begin
        exp_w = expected_writes.pop_front();
        if (out_ch.write_address !== exp_w.address || out_ch.write_data !== exp_w.data ||
            out_ch.last_write !== exp_w.last) begin
          mismatch_count++;
          $display("%0t write mismatch: expected addr %h data %h last %b,",
                   $time, exp_w.address, exp_w.data, exp_w.last,
                   " got addr %h data %h last %b",
                   out_ch.write_address, out_ch.write_data, out_ch.last_write);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic push_cmd(input logic op, input logic sel, input logic val);
    pending_cmds.push_back(led_cmd_t'{opcode: op, line_select: sel, line_value: val});
  endtask

  // mostly set commands, some init commands, random lines and values
  task automatic push_random_cmds(input int count);
    for (int i = 0; i < count; i++) begin
      push_cmd(($urandom_range(0, 99) < 15) ? OP_INIT : OP_SET,
               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    end
  endtask

  // wait for every queued command and every write, then let a lone set finish
  // checked on the falling edge so the clocked blocks have settled
  task automatic wait_idle();
    while (pending_cmds.size() != 0 || in_ch.valid || expected_writes.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_window_base(input logic [31:0] value);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    base_copy = value;
  endtask

  initial begin
    // known values on every input from time zero
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_wr_data       = 32'd0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = OP_SET;
    in_ch.line_select = LINE_DISK3;
    in_ch.line_value  = 1'b0;
    out_ch.ready      = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // directed walk over every line transition, window base at reset value
    send_idle_pct = 36;
    recv_idle_pct = 83;
    push_cmd(OP_SET, LINE_DISK3, 1'b0);   // no change from reset
    push_cmd(OP_SET, LINE_DISK4, 1'b0);   // no change
    push_cmd(OP_INIT, LINE_DISK3, 1'b0);
    push_cmd(OP_SET, LINE_DISK3, 1'b1);   // to disk3
    push_cmd(OP_SET, LINE_DISK3, 1'b1);   // no change
    push_cmd(OP_SET, LINE_DISK4, 1'b1);   // to disk34
    push_cmd(OP_INIT, LINE_DISK4, 1'b1);  // lines kept
    push_cmd(OP_SET, LINE_DISK4, 1'b1);   // no change
    push_cmd(OP_SET, LINE_DISK3, 1'b0);   // to disk4
    push_cmd(OP_SET, LINE_DISK4, 1'b0);   // to both-off
    push_cmd(OP_SET, LINE_DISK4, 1'b1);
    push_cmd(OP_SET, LINE_DISK3, 1'b1);
    push_cmd(OP_SET, LINE_DISK4, 1'b0);
    push_cmd(OP_SET, LINE_DISK3, 1'b0);
    push_cmd(OP_INIT, LINE_DISK4, 1'b0);
    push_cmd(OP_INIT, LINE_DISK3, 1'b1);
    push_cmd(OP_SET, LINE_DISK4, 1'b1);
    push_cmd(OP_SET, LINE_DISK4, 1'b0);
    wait_idle();

    // highest window base
    write_window_base(32'hffff_ff00);
    push_random_cmds(80);
    wait_idle();

    // swap the idle rates, alternating base bits
    send_idle_pct = 83;
    recv_idle_pct = 36;
    write_window_base(32'h5555_55aa);
    push_random_cmds(80);
    wait_idle();

    // no idling, one long receiver hold-off while commands keep coming
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_window_base(32'haaaa_aa55);
    hold_req = ~hold_req;
    push_random_cmds(80);
    wait_idle();

    // back to a zero base, then a random one
    write_window_base(32'd0);
    push_random_cmds(10);
    wait_idle();
    write_window_base($urandom_range(0, 32'hffff_ff00));
    push_random_cmds(10);
    wait_idle();

    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/lws_pkg.sv
src/lws_if.sv
src/led_line_write_sequencer.sv
tb/led_line_write_sequencer_tb.sv
